### design/bdhd_pkg.sv
package bdhd_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned DebW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  // request selector
  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INVERT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOLD     = 2'd2;

  localparam logic [DebW-1:0]  DEBOUNCE_RST = 16'd25;
  localparam logic             INVERT_RST   = 1'b1;
  localparam logic [TimeW-1:0] HOLD_RST     = 32'd1000;

  typedef struct packed {
    logic [DebW-1:0]  debounce_ms;
    logic             invert_input;
    logic [TimeW-1:0] hold_ms;
  } bdhd_cfg_t;

  typedef struct packed {
    logic             op;
    logic             raw_level;
    logic [TimeW-1:0] now_ms;
  } bdhd_req_t;

  typedef struct packed {
    logic             level;
    logic             stable;
    logic             changed;
    logic             press_edge;
    logic             release_edge;
    logic             held_long;
    logic             idle_long;
    logic [TimeW-1:0] last_change_ms;
  } bdhd_res_t;

endpackage

### design/bdhd_cfg.sv
module bdhd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [bdhd_pkg::CfgIdxW-1:0]   wr_index,
  input  logic [bdhd_pkg::CfgDataW-1:0]  wr_data,
  output bdhd_pkg::bdhd_cfg_t            cfg
);
  import bdhd_pkg::*;

  bdhd_cfg_t cfg_r;
  bdhd_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_DEBOUNCE: cfg_nxt.debounce_ms  = wr_data[DebW-1:0];
        CFG_INVERT:   cfg_nxt.invert_input = wr_data[0];
        CFG_HOLD:     cfg_nxt.hold_ms      = wr_data[TimeW-1:0];
        default:      cfg_nxt = cfg_r;   // unused index: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms  <= DEBOUNCE_RST;
      cfg_r.invert_input <= INVERT_RST;
      cfg_r.hold_ms      <= HOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### design/bdhd_core.sv
module bdhd_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  bdhd_pkg::bdhd_req_t  req,
  input  bdhd_pkg::bdhd_cfg_t  cfg,
  output bdhd_pkg::bdhd_res_t  res
);
  import bdhd_pkg::*;

  logic             dl_r, dl_nxt;      // debounced level
  logic             lr_r, lr_nxt;      // last raw level
  logic             st_r, st_nxt;
  logic             ch_r, ch_nxt;
  logic [TimeW-1:0] qs_r, qs_nxt;      // quiet start
  logic [TimeW-1:0] ct_r, ct_nxt;      // change time

  logic             lvl;
  logic             raw_chg;
  logic             accept;
  logic             lvl_flip;
  logic             new_ct;
  logic             hold_met;
  logic [TimeW-1:0] quiet_age;
  logic [TimeW-1:0] since_old;

  assign lvl       = req.raw_level ^ cfg.invert_input;
  assign raw_chg   = lvl != lr_r;
  assign quiet_age = req.now_ms - qs_r;
  // a raw change restarts the quiet timer and blocks acceptance of this sample
  assign accept    = !raw_chg && (quiet_age > {{(TimeW-DebW){1'b0}}, cfg.debounce_ms});
  assign lvl_flip  = accept && (dl_r != lvl);
  assign new_ct    = (req.op == OP_START) || lvl_flip;
  assign since_old = req.now_ms - ct_r;
  // fresh time stamp means zero elapsed time
  assign hold_met  = new_ct ? (cfg.hold_ms == '0) : (since_old >= cfg.hold_ms);

  always_comb begin
    dl_nxt = dl_r;
    lr_nxt = lvl;
    st_nxt = st_r;
    ch_nxt = ch_r;
    qs_nxt = qs_r;
    ct_nxt = ct_r;
    unique case (req.op)
      OP_START: begin
        dl_nxt = lvl;
        lr_nxt = ~lvl;
        st_nxt = 1'b0;
        ch_nxt = 1'b0;
        qs_nxt = req.now_ms;
        ct_nxt = req.now_ms;
      end
      OP_SAMPLE: begin
        if (raw_chg) begin
          qs_nxt = req.now_ms;
          st_nxt = 1'b0;
          ch_nxt = 1'b0;
        end
        if (accept) begin
          dl_nxt = lvl;
          st_nxt = 1'b1;
          ch_nxt = lvl_flip;
        end
        if (lvl_flip) begin
          ct_nxt = req.now_ms;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_r <= 1'b0;
      lr_r <= 1'b1;
      st_r <= 1'b0;
      ch_r <= 1'b0;
      qs_r <= '0;
      ct_r <= '0;
    end else if (go) begin
      dl_r <= dl_nxt;
      lr_r <= lr_nxt;
      st_r <= st_nxt;
      ch_r <= ch_nxt;
      qs_r <= qs_nxt;
      ct_r <= ct_nxt;
    end
  end

  always_comb begin
    res.level          = dl_nxt;
    res.stable         = st_nxt;
    res.changed        = ch_nxt;
    res.press_edge     = dl_nxt & ch_nxt;
    res.release_edge   = ~dl_nxt & ch_nxt;
    res.held_long      = dl_nxt & hold_met;
    res.idle_long      = ~dl_nxt & hold_met;
    res.last_change_ms = ct_nxt;
  end

  a_change_stamped: assert property (@(posedge clk) disable iff (!rst_n)
    go && lvl_flip && (req.op == OP_SAMPLE) |-> res.last_change_ms == req.now_ms)
    else $error("level change not time-stamped with the request time");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    go && (req.op == OP_START) |=> !st_r && !ch_r && (lr_r != dl_r))
    else $error("start did not initialise the state");

  a_quiet_restart: assert property (@(posedge clk) disable iff (!rst_n)
    go && (req.op == OP_SAMPLE) && raw_chg |-> !res.stable && !res.changed)
    else $error("raw change did not clear stable and changed");

endmodule

### design/button_debounce_hold_detector.sv
// Button debouncer with long-press detection.
//
// Input channel (in_valid/in_ready): one request per button sample, carrying
// the raw pin level, a 32-bit millisecond time stamp and a selector
// (start re-initialises from this sample, otherwise a normal sample).
// Result channel (out_valid/out_ready): exactly one result per request, in
// order: debounced level, stable, changed, press/release edges, held/idle
// long flags and the time stamp of the last level change.
// Config channel (cfg_valid/cfg_ready): index 0 debounce time, 1 invert,
// 2 hold time. Always ready; write only while the block is idle.
//
// Pipeline: a request goes through the input register, then the result
// register, moving on when go is high. Throughput is one request per cycle
// while the receiver takes results (out_ready); each request's state update
// uses two parallel 32-bit subtract/compare paths.
// Reset (rst_n low, synchronous) restores register defaults (25, 1, 1000)
// and the debouncer state, and empties both stages.
// A stalled receiver holds the result register; the input register still
// takes one more request, after which in_ready drops until out_ready returns.
module button_debounce_hold_detector (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic                           in_raw_level,
  input  logic [bdhd_pkg::TimeW-1:0]     in_now_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_level,
  output logic                           out_stable,
  output logic                           out_changed,
  output logic                           out_press_edge,
  output logic                           out_release_edge,
  output logic                           out_held_long,
  output logic                           out_idle_long,
  output logic [bdhd_pkg::TimeW-1:0]     out_last_change_ms,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bdhd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bdhd_pkg::CfgDataW-1:0]  cfg_data
);
  import bdhd_pkg::*;

  bdhd_cfg_t cfg;
  bdhd_req_t req_r;
  bdhd_res_t res;
  bdhd_res_t res_r;
  logic      req_vld_r;
  logic      out_vld_r;
  logic      go;        // request in the input stage moves to the result stage

  assign cfg_ready = 1'b1;

  bdhd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign go       = req_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !req_vld_r || go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_ready) begin
      req_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.op        <= in_op;
      req_r.raw_level <= in_raw_level;
      req_r.now_ms    <= in_now_ms;
    end
  end

  bdhd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .req   (req_r),
    .cfg   (cfg),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (go) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_level          = res_r.level;
  assign out_stable         = res_r.stable;
  assign out_changed        = res_r.changed;
  assign out_press_edge     = res_r.press_edge;
  assign out_release_edge   = res_r.release_edge;
  assign out_held_long      = res_r.held_long;
  assign out_idle_long      = res_r.idle_long;
  assign out_last_change_ms = res_r.last_change_ms;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> req_vld_r && out_vld_r && !out_ready)
    else $error("input stalled with room in the pipeline");

  a_edge_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (res_r.press_edge || res_r.release_edge) |-> res_r.changed && res_r.stable)
    else $error("edge reported without an accepted level change");

  a_long_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(res_r.held_long && res_r.idle_long))
    else $error("held and idle reported together");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r && !req_vld_r)
    else $error("pipeline not empty after reset");

endmodule
